/* rtl/hsvha_pkg.sv */
// Package for the HSV hue and saturation adjust block: pixel structs, fixed-point
// constants, register indexes and the four-bit division step.
// No dependencies.
`default_nettype none

package hsvha_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef enum logic {
    REG_HUE_SHIFT  = 1'b0,
    REG_SAT_REDUCE = 1'b1
  } cfg_reg_e;

  localparam int unsigned NumStages = 10;
  localparam logic [18:0] HueTurn   = 19'd393216;
  localparam logic [24:0] Recip255  = 25'd16843010;

  typedef struct packed {
    logic [7:0] rem;
    logic [3:0] bits;
  } div_step_t;

  function automatic div_step_t div_step4(logic [7:0] rem, logic [7:0] den);
    logic [8:0] acc;
    div_step_t  res;
    res.rem  = rem;
    res.bits = '0;
    for (int i = 3; i >= 0; i--) begin
      acc = {res.rem, 1'b0};
      if (acc >= {1'b0, den}) begin
        acc         = acc - {1'b0, den};
        res.bits[i] = 1'b1;
      end
      res.rem = acc[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/hsvha_div.sv */
// Pipelined divider giving floor(num * 2^16 / den) in four register stages.
// Depends on hsvha_pkg for the division step.
`default_nettype none

module hsvha_div import hsvha_pkg::*; (
  input  logic        clk_i,
  input  logic [3:0]  en_i,
  input  logic [7:0]  num_i,
  input  logic [7:0]  den_i,
  output logic [16:0] quot_o,
  output logic        rem_nz_o
);

  logic [7:0]  den_q  [3];
  logic [7:0]  rem_q  [4];
  logic [16:0] quot_q [4];

  logic       int_bit;
  logic [7:0] rem_init;
  div_step_t  step0;

  assign int_bit  = (num_i >= den_i);
  assign rem_init = int_bit ? (num_i - den_i) : num_i;
  assign step0    = div_step4(rem_init, den_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      den_q[0]  <= den_i;
      rem_q[0]  <= step0.rem;
      quot_q[0] <= {int_bit, step0.bits, 12'b0};
    end
  end

  for (genvar k = 1; k < 4; k++) begin : g_stage
    div_step_t   step;
    logic [16:0] quot_d;
    assign step   = div_step4(rem_q[k-1], den_q[k-1]);
    assign quot_d = quot_q[k-1] | (17'(step.bits) << (12 - 4 * k));
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= step.rem;
        quot_q[k] <= quot_d;
      end
    end
    if (k < 3) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quot_o   = quot_q[3];
  assign rem_nz_o = |rem_q[3];

endmodule

`default_nettype wire

/* rtl/hsv_hue_saturation_adjust_top.sv */
// A pixel is registered in turn by stages 0 to 9, the last being the output register,
// and its result is held there while the output stalls.
// Throughput: one pixel per cycle; each stage holds when the next one is full and cannot pass its pixel on.
// Reset clears all stage valid bits, zeroes the hue shift and sets keep_q to 255.
// Depends on hsvha_pkg and hsvha_div.
`default_nettype none

module hsv_hue_saturation_adjust_top import hsvha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pix_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_data_o
);

  logic [18:0] shift_q;
  logic [7:0]  keep_q;
  logic [10:0] prod6;
  logic [2:0]  corr;
  logic [18:0] shift_d;

  always_comb begin
    prod6 = 11'(cfg_data_i) * 11'd6;
    corr  = '0;
    for (int t = 1; t <= 6; t++) begin
      if (prod6 >= 11'(t * 255)) begin
        corr = corr + 3'd1;
      end
    end
    shift_d = 19'(cfg_data_i) * 19'd1542 + 19'(corr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      keep_q  <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HUE_SHIFT:  shift_q <= shift_d;
        REG_SAT_REDUCE: keep_q  <= 8'd255 - cfg_data_i;
      endcase
    end
  end

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;

  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NumStages-1];

  // Stage 0: max, min and the hue numerator.
  logic [7:0] mx_c, mn_c, plus_c, minus_c;
  logic [2:0] base_c;

  always_comb begin
    mx_c = in_data_i.red_in;
    mn_c = in_data_i.red_in;
    if (in_data_i.green_in > mx_c) mx_c = in_data_i.green_in;
    if (in_data_i.blue_in > mx_c)  mx_c = in_data_i.blue_in;
    if (in_data_i.green_in < mn_c) mn_c = in_data_i.green_in;
    if (in_data_i.blue_in < mn_c)  mn_c = in_data_i.blue_in;
    priority if (in_data_i.red_in == mx_c) begin
      base_c  = 3'd0;
      plus_c  = in_data_i.green_in;
      minus_c = in_data_i.blue_in;
    end else if (in_data_i.green_in == mx_c) begin
      base_c  = 3'd2;
      plus_c  = in_data_i.blue_in;
      minus_c = in_data_i.red_in;
    end else begin
      base_c  = 3'd4;
      plus_c  = in_data_i.red_in;
      minus_c = in_data_i.green_in;
    end
  end

  logic [7:0] mx_q    [NumStages-1];
  logic       flat_q  [7];
  logic [2:0] base_q  [5];
  logic       neg_q   [5];
  logic [7:0] delta_q;
  logic [7:0] dabs_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mx_q[0]   <= mx_c;
      flat_q[0] <= (mx_c == mn_c);
      base_q[0] <= base_c;
      neg_q[0]  <= (plus_c < minus_c);
      delta_q   <= mx_c - mn_c;
      dabs_q    <= (plus_c < minus_c) ? (minus_c - plus_c) : (plus_c - minus_c);
    end
    for (int k = 1; k < 5; k++) begin
      if (rdy[k]) begin
        base_q[k] <= base_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
    end
    for (int k = 1; k < 7; k++) begin
      if (rdy[k]) begin
        flat_q[k] <= flat_q[k-1];
      end
    end
    for (int k = 1; k < NumStages - 1; k++) begin
      if (rdy[k]) begin
        mx_q[k] <= mx_q[k-1];
      end
    end
  end

  // Stages 1 to 4: saturation and hue fraction dividers.
  logic [16:0] sat_quot, hue_quot;
  logic        sat_nz, hue_nz;

  hsvha_div u_sat_div (
    .clk_i    (clk_i),
    .en_i     (rdy[4:1]),
    .num_i    (delta_q),
    .den_i    (mx_q[0]),
    .quot_o   (sat_quot),
    .rem_nz_o (sat_nz)
  );

  hsvha_div u_hue_div (
    .clk_i    (clk_i),
    .en_i     (rdy[4:1]),
    .num_i    (dabs_q),
    .den_i    (delta_q),
    .quot_o   (hue_quot),
    .rem_nz_o (hue_nz)
  );

  // Stage 5: saturation times the keep factor, unwrapped hue.
  logic [24:0] zprod;
  logic [20:0] hbase, hpre_d;
  logic [23:0] z_q;
  logic [20:0] hpre_q;
  logic        unused_sat_nz;

  assign unused_sat_nz = sat_nz;
  assign zprod = 25'(sat_quot) * 25'(keep_q);
  assign hbase = {2'b0, base_q[4], 16'b0} + 21'(HueTurn) + 21'(shift_q);
  assign hpre_d = neg_q[4] ? (hbase - 21'(hue_quot) - 21'(hue_nz)) : (hbase + 21'(hue_quot));

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      z_q    <= zprod[23:0];
      hpre_q <= hpre_d;
    end
  end

  // Stage 6: divide by 255 through the reciprocal, wrap the hue.
  logic [48:0] rprod;
  logic [18:0] h_d;
  logic [16:0] sat2_q;
  logic [18:0] h_q;

  assign rprod = 49'(z_q) * 49'(Recip255);

  always_comb begin
    priority if (hpre_q >= 21'(2 * HueTurn)) begin
      h_d = 19'(hpre_q - 21'(2 * HueTurn));
    end else if (hpre_q >= 21'(HueTurn)) begin
      h_d = 19'(hpre_q - 21'(HueTurn));
    end else begin
      h_d = hpre_q[18:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      sat2_q <= rprod[48:32];
      h_q    <= h_d;
    end
  end

  // Stage 7: saturation times hue fraction.
  logic [32:0] sf;
  logic [33:0] sfc;
  logic [16:0] pc_q;
  logic [32:0] qc_q, tc_q;
  logic [2:0]  sec_q [2];
  logic        flat7_q, flat8_q;

  assign sf  = 33'(sat2_q) * 33'(h_q[15:0]);
  assign sfc = 34'(sat2_q) * (34'd65536 - 34'(h_q[15:0]));

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      pc_q     <= 17'd65536 - sat2_q;
      qc_q     <= 33'h1_0000_0000 - sf;
      tc_q     <= 33'(34'h1_0000_0000 - sfc);
      sec_q[0] <= h_q[18:16];
      flat7_q  <= flat_q[6] | (sat2_q == '0);
    end
  end

  // Stage 8: scale by value.
  logic [24:0] pprod;
  logic [40:0] qprod, tprod;
  logic [7:0]  p_q, q_q, t_q;

  assign pprod = 25'(mx_q[7]) * 25'(pc_q);
  assign qprod = 41'(mx_q[7]) * 41'(qc_q);
  assign tprod = 41'(mx_q[7]) * 41'(tc_q);

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      p_q      <= pprod[23:16];
      q_q      <= qprod[39:32];
      t_q      <= tprod[39:32];
      sec_q[1] <= sec_q[0];
      flat8_q  <= flat7_q;
    end
  end

  // Stage 9: sector selection into the output register.
  pix_out_t res_d, res_q;
  logic [7:0] v8;

  assign v8 = mx_q[8];

  always_comb begin
    if (flat8_q) begin
      res_d = '{v8, v8, v8};
    end else begin
      unique case (sec_q[1])
        3'd0:    res_d = '{v8, t_q, p_q};
        3'd1:    res_d = '{q_q, v8, p_q};
        3'd2:    res_d = '{p_q, v8, t_q};
        3'd3:    res_d = '{p_q, q_q, v8};
        3'd4:    res_d = '{t_q, p_q, v8};
        default: res_d = '{v8, p_q, q_q};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

endmodule

`default_nettype wire

/* rtl/hsvha_checker.sv */
// Port-level checker for the HSV hue and saturation adjust block, with its bind.
// Depends on hsvha_pkg and hsv_hue_saturation_adjust_top.
`default_nettype none

module hsvha_checker import hsvha_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     cfg_we_i,
  input logic     cfg_idx_i,
  input logic [7:0] cfg_data_i,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input pix_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pix_out_t out_data_o
);

  logic [4:0] cnt_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 5'(in_xfer) - 5'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input held off with no result waiting");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 5'd0)
    else $error("result without an accepted pixel");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(NumStages))
    else $error("more pixels in flight than stages");

  logic unused_ok;
  assign unused_ok = cfg_we_i ^ cfg_idx_i ^ (|cfg_data_i) ^ (|in_data_i);

endmodule

bind hsv_hue_saturation_adjust_top hsvha_checker u_checker (.*);

`default_nettype wire

/* test/tb_hsv_hue_saturation_adjust_top.sv */
// Testbench for hsv_hue_saturation_adjust_top: a directed table and random pixels,
// checked against a fixed-point hue and saturation predictor. Depends on hsvha_pkg and hsv_hue_saturation_adjust_top.
`timescale 1ns / 100ps

module tb_hsv_hue_saturation_adjust_top;
  import hsvha_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  cfg_reg_e cfg_idx_i = REG_HUE_SHIFT;
  logic [7:0] cfg_data_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  pix_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  pix_out_t out_data_o;

  hsv_hue_saturation_adjust_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  typedef struct {
    pix_in_t  pix;
    logic     typed;
    pix_out_t want;
  } row_t;

  logic [7:0] hue_shift_q = '0;
  logic [7:0] sat_reduce_q = '0;
  pix_out_t   pixel_q[$];
  int         errors = 0;
  int         pixels_sent = 0;
  int         pixels_checked = 0;
  int         send_idle = 0;
  int         recv_stall = 0;

  function automatic pix_out_t adjust_pixel(pix_in_t p);
    longint unsigned r, g, b, mx, mn, d, sat, sat2, h, f, pp, qq, tt, base, pl, mi;
    longint unsigned ro, go, bo;
    pix_out_t o;
    r = p.red_in; g = p.green_in; b = p.blue_in;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    ro = mx; go = mx; bo = mx;
    if (mx != mn) begin
      d = mx - mn;
      sat = (d * 65536) / mx;
      sat2 = (sat * (255 - sat_reduce_q)) / 255;
      if (sat2 != 0) begin
        if (r == mx) begin
          base = 0; pl = g; mi = b;
        end else if (g == mx) begin
          base = 2; pl = b; mi = r;
        end else begin
          base = 4; pl = r; mi = g;
        end
        h = ((((base + 6) * d + pl - mi) * 65536) / d) % 393216;
        h = (h + (hue_shift_q * 64'd393216) / 255) % 393216;
        f = h & 16'hFFFF;
        pp = (mx * (65536 - sat2)) >> 16;
        qq = (mx * ((64'd1 << 32) - sat2 * f)) >> 32;
        tt = (mx * ((64'd1 << 32) - sat2 * (65536 - f))) >> 32;
        case (h >> 16)
          0: begin ro = mx; go = tt; bo = pp; end
          1: begin ro = qq; go = mx; bo = pp; end
          2: begin ro = pp; go = mx; bo = tt; end
          3: begin ro = pp; go = qq; bo = mx; end
          4: begin ro = tt; go = pp; bo = mx; end
          default: begin ro = mx; go = pp; bo = qq; end
        endcase
      end
    end
    o.red_out = (ro > 255) ? 8'd255 : ro[7:0];
    o.green_out = (go > 255) ? 8'd255 : go[7:0];
    o.blue_out = (bo > 255) ? 8'd255 : bo[7:0];
    return o;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_HUE_SHIFT) hue_shift_q = val;
    else sat_reduce_q = val;
  endtask

  task automatic send_pixel(pix_in_t p, logic typed, pix_out_t want);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pixel_q.push_back(typed ? want : adjust_pixel(p));
    pixels_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    if (out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h", $time, out_data_o);
        errors++;
      end else begin
        pix_out_t want;
        want = pixel_q.pop_front();
        if (want.red_out !== out_data_o.red_out) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red_out,
                   out_data_o.red_out);
          errors++;
        end
        if (want.green_out !== out_data_o.green_out) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green_out,
                   out_data_o.green_out);
          errors++;
        end
        if (want.blue_out !== out_data_o.blue_out) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue_out,
                   out_data_o.blue_out);
          errors++;
        end
        pixels_checked++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[hsv_hue_saturation_adjust_top] ERROR");
    $finish;
  end

  initial begin
    row_t rows[$];
    pix_in_t p;
    int hs[8] = '{0, 255, 0, 128, 1, 255, 200, 0};
    int sr[8] = '{0, 0, 255, 100, 254, 255, 0, 1};
    rows = '{
      '{'{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{'{8'd77, 8'd77, 8'd77}, 1'b1, '{8'd77, 8'd77, 8'd77}},
      '{'{8'd255, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd0, 8'd0}},
      '{'{8'd0, 8'd255, 8'd0}, 1'b1, '{8'd0, 8'd255, 8'd0}},
      '{'{8'd0, 8'd0, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd255}},
      '{'{8'd255, 8'd255, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd255, 8'd255}, 1'b0, '0},
      '{'{8'd255, 8'd0, 8'd255}, 1'b0, '0},
      '{'{8'd1, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd255, 8'd254, 8'd254}, 1'b0, '0},
      '{'{8'd200, 8'd100, 8'd150}, 1'b0, '0},
      '{'{8'd10, 8'd240, 8'd37}, 1'b0, '0},
      '{'{8'd33, 8'd66, 8'd250}, 1'b0, '0},
      '{'{8'd170, 8'd85, 8'd170}, 1'b0, '0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_pixel(rows[i].pix, rows[i].typed, rows[i].want);
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 8) begin
        write_reg(REG_HUE_SHIFT, 8'(hs[ph]));
        write_reg(REG_SAT_REDUCE, 8'(sr[ph]));
      end else begin
        write_reg(REG_HUE_SHIFT, 8'($urandom_range(255)));
        write_reg(REG_SAT_REDUCE, 8'($urandom_range(255)));
      end
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 84; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 84; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      for (int n = 0; n < 158; n++) begin
        p = $urandom;
        if ($urandom_range(19) == 0) p.green_in = p.red_in;
        if ($urandom_range(19) == 0) begin
          p.green_in = p.red_in;
          p.blue_in = p.red_in;
        end
        send_pixel(p, 1'b0, '0);
      end
      drain();
    end
    $display("Sent %0d pixels and checked %0d results over twelve register settings,",
             pixels_sent, pixels_checked);
    $display("with sender gaps and receiver stalls in turn.");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("[hsv_hue_saturation_adjust_top] OK");
    end else begin
      $display("[hsv_hue_saturation_adjust_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hsvha_pkg.sv
rtl/hsvha_div.sv
rtl/hsv_hue_saturation_adjust_top.sv
rtl/hsvha_checker.sv
test/tb_hsv_hue_saturation_adjust_top.sv
